>>> rtl/brhp_pkg.sv
// Shared types, character constants and tables for the byte range header parser.
package brhp_pkg;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_LEFT   = 2'd1,
    PH_RIGHT  = 2'd2
  } phase_t;

  localparam int PrefixLen = 6;

  localparam logic [15:0] ChDash     = 16'h002D;
  localparam logic [15:0] ChZero     = 16'h0030;
  localparam logic [15:0] ChNine     = 16'h0039;
  localparam logic [15:0] ChUpperA   = 16'h0041;
  localparam logic [15:0] ChUpperZ   = 16'h005A;
  localparam logic [15:0] CaseOffset = 16'h0020;

  // Expected lower-case prefix character "bytes=" at each position.
  function automatic logic [15:0] prefix_char(input logic [2:0] pos);
    logic [15:0] ch;
    case (pos)
      3'd0:    ch = 16'h0062;  // b
      3'd1:    ch = 16'h0079;  // y
      3'd2:    ch = 16'h0074;  // t
      3'd3:    ch = 16'h0065;  // e
      3'd4:    ch = 16'h0073;  // s
      3'd5:    ch = 16'h003D;  // =
      default: ch = 16'h0000;
    endcase
    return ch;
  endfunction

  typedef struct packed {
    logic        has_char;
    logic [15:0] char_code;
    logic        is_last;
    logic [63:0] resource_size;
  } item_t;

  // Parser state captured at the end of a header, plus the resource size.
  typedef struct packed {
    logic        empty;
    logic        failed;
    phase_t      phase;
    logic [63:0] left_value;
    logic        left_seen;
    logic [63:0] right_value;
    logic        right_seen;
    logic [63:0] size;
  } fin_t;

  typedef struct packed {
    logic        status;
    logic [63:0] range_first;
    logic [63:0] range_last;
    logic        partial;
  } res_t;

endpackage

>>> rtl/brhp_if.sv
// Valid/ready channel interfaces for header characters and resolved ranges.
interface brhp_in_if;
  logic        valid;
  logic        ready;
  logic        has_char;
  logic [15:0] char_code;
  logic        is_last;
  logic [63:0] resource_size;

  modport source (output valid, has_char, char_code, is_last, resource_size, input ready);
  modport sink   (input valid, has_char, char_code, is_last, resource_size, output ready);
endinterface

interface brhp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] range_first;
  logic [63:0] range_last;
  logic        partial;

  modport source (output valid, status, range_first, range_last, partial, input ready);
  modport sink   (input valid, status, range_first, range_last, partial, output ready);
endinterface

>>> rtl/brhp_step.sv
// Per-character parser: prefix match, phase tracking and decimal accumulators.
module brhp_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  brhp_pkg::item_t    item,
  output brhp_pkg::fin_t     fin,
  output logic               hdr_end
);

  brhp_pkg::phase_t phase, phase_next;
  logic [2:0]       prefix_pos, prefix_pos_next;
  logic             failed, failed_next;
  logic [63:0]      left_value, left_value_next;
  logic             left_seen, left_seen_next;
  logic [63:0]      right_value, right_value_next;
  logic             right_seen, right_seen_next;

  logic        digit;
  logic [15:0] lower;
  logic [63:0] acc_in;
  logic [67:0] acc_sum;
  logic        acc_ovf;

  // acc * 10 + digit, with the carry-out bits flagging overflow past 64 bits.
  always_comb begin
    digit   = (item.char_code >= brhp_pkg::ChZero) && (item.char_code <= brhp_pkg::ChNine);
    lower   = ((item.char_code >= brhp_pkg::ChUpperA) && (item.char_code <= brhp_pkg::ChUpperZ))
              ? item.char_code + brhp_pkg::CaseOffset : item.char_code;
    acc_in  = (phase == brhp_pkg::PH_LEFT) ? left_value : right_value;
    acc_sum = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1) + {64'b0, item.char_code[3:0]};
    acc_ovf = |acc_sum[67:64];
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    prefix_pos_next  = prefix_pos;
    failed_next      = failed;
    left_value_next  = left_value;
    left_seen_next   = left_seen;
    right_value_next = right_value;
    right_seen_next  = right_seen;
    if (item.has_char && !failed) begin
      unique case (phase)
        brhp_pkg::PH_PREFIX: begin
          if ((prefix_pos >= 3'(brhp_pkg::PrefixLen)) ||
              (lower != brhp_pkg::prefix_char(prefix_pos))) begin
            failed_next = 1'b1;
          end else begin
            prefix_pos_next = prefix_pos + 3'd1;
            if (prefix_pos == 3'(brhp_pkg::PrefixLen - 1)) begin
              phase_next = brhp_pkg::PH_LEFT;
            end
          end
        end
        brhp_pkg::PH_LEFT: begin
          if (item.char_code == brhp_pkg::ChDash) begin
            phase_next = brhp_pkg::PH_RIGHT;
          end else if (digit) begin
            if (acc_ovf) failed_next = 1'b1;
            else         left_value_next = acc_sum[63:0];
            left_seen_next = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        brhp_pkg::PH_RIGHT: begin
          if (digit) begin
            if (acc_ovf) failed_next = 1'b1;
            else         right_value_next = acc_sum[63:0];
            right_seen_next = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase
    end
  end

  // Outputs: state as it stands after this item, for resolution
  always_comb begin
    hdr_end         = !item.has_char || item.is_last;
    fin.empty       = !item.has_char && (phase == brhp_pkg::PH_PREFIX) &&
                      (prefix_pos == 3'd0) && !failed;
    fin.failed      = failed_next;
    fin.phase       = phase_next;
    fin.left_value  = left_value_next;
    fin.left_seen   = left_seen_next;
    fin.right_value = right_value_next;
    fin.right_seen  = right_seen_next;
    fin.size        = item.resource_size;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && hdr_end)) begin
      phase       <= brhp_pkg::PH_PREFIX;
      prefix_pos  <= 3'd0;
      failed      <= 1'b0;
      left_value  <= 64'd0;
      left_seen   <= 1'b0;
      right_value <= 64'd0;
      right_seen  <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      prefix_pos  <= prefix_pos_next;
      failed      <= failed_next;
      left_value  <= left_value_next;
      left_seen   <= left_seen_next;
      right_value <= right_value_next;
      right_seen  <= right_seen_next;
    end
  end

endmodule

>>> rtl/brhp_resolve.sv
// Turns a finished header into a clamped byte range or an invalid status.
module brhp_resolve (
  input  brhp_pkg::fin_t fin,
  output brhp_pkg::res_t res
);

  logic [63:0] size_m1;
  logic [63:0] suffix_first;
  logic        ok;
  logic [63:0] first;
  logic [63:0] last;
  logic        part;

  always_comb begin
    size_m1      = fin.size - 64'd1;
    suffix_first = (fin.right_value >= fin.size) ? 64'd0 : fin.size - fin.right_value;
    ok    = 1'b0;
    first = 64'd0;
    last  = size_m1;
    part  = 1'b1;
    if (fin.size == 64'd0) begin
      ok = 1'b0;
    end else if (fin.empty) begin
      ok   = 1'b1;
      part = 1'b0;
    end else if (fin.failed || (fin.phase != brhp_pkg::PH_RIGHT)) begin
      ok = 1'b0;
    end else if (!fin.left_seen) begin
      // suffix form: last N bytes
      ok    = fin.right_seen && (fin.right_value != 64'd0);
      first = suffix_first;
    end else if (fin.left_value >= fin.size) begin
      ok = 1'b0;
    end else if (!fin.right_seen) begin
      ok    = 1'b1;
      first = fin.left_value;
    end else begin
      ok    = fin.left_value <= fin.right_value;
      first = fin.left_value;
      last  = (fin.right_value < size_m1) ? fin.right_value : size_m1;
    end

    res.status      = !ok;
    res.range_first = ok ? first : 64'd0;
    res.range_last  = ok ? last : 64'd0;
    res.partial     = ok && part;
  end

endmodule

>>> rtl/byte_range_header_parser_unit.sv
// Top level: byte range header parser, one character per item.
// A header-ending item goes via the input register and stage 2 to the result register.
// Throughput: one item per cycle while rng is ready; input register, parser step, then a
//   resolution stage feeding the result register, all advancing on a shared ready chain.
// Reset (rst, synchronous, active high) empties all stages and puts the parser
//   at the start of a header; no clearing pass.
module byte_range_header_parser_unit (
  input logic       clk,
  input logic       rst,
  brhp_in_if.sink   hdr,
  brhp_out_if.source rng
);

  // Stage 1: registered input item
  logic            v1;
  brhp_pkg::item_t item1;

  // Stage 2: finished header awaiting resolution
  logic            v2;
  brhp_pkg::fin_t  fin2;

  // Stage 3: result register
  logic            v3;
  brhp_pkg::res_t  res3;

  logic            ready3, ready2, consume1;
  brhp_pkg::fin_t  fin;
  logic            hdr_end;
  brhp_pkg::res_t  res;

  // Ready chain: each stage moves when the one ahead is empty or moving.
  assign ready3   = !v3 || rng.ready;
  assign ready2   = !v2 || ready3;
  assign consume1 = v1 && ready2;
  assign hdr.ready = !v1 || consume1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (hdr.valid && hdr.ready) begin
      v1 <= 1'b1;
    end else if (consume1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      item1.has_char      <= hdr.has_char;
      item1.char_code     <= hdr.char_code;
      item1.is_last       <= hdr.is_last;
      item1.resource_size <= hdr.resource_size;
    end
  end

  // Parser state advances once per consumed item
  brhp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (consume1),
    .item    (item1),
    .fin     (fin),
    .hdr_end (hdr_end)
  );

  // Only header-ending items produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (consume1 && hdr_end) begin
      v2 <= 1'b1;
    end else if (v2 && ready3) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume1 && hdr_end) begin
      fin2 <= fin;
    end
  end

  brhp_resolve u_resolve (
    .fin (fin2),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (v2 && ready3) begin
      v3 <= 1'b1;
    end else if (rng.ready) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      res3 <= res;
    end
  end

  assign rng.valid       = v3;
  assign rng.status      = res3.status;
  assign rng.range_first = res3.range_first;
  assign rng.range_last  = res3.range_last;
  assign rng.partial     = res3.partial;

  // An invalid result carries all-zero range fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rng.valid && rng.status) |->
      (rng.range_first == 64'd0) && (rng.range_last == 64'd0) && !rng.partial)
    else $error("invalid result with nonzero range fields");

  // A valid range is never reversed.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (rng.valid && !rng.status) |-> (rng.range_first <= rng.range_last))
    else $error("valid result with first above last");

  // A header-ending item always lands in the resolution stage.
  a_end_captured: assert property (@(posedge clk) disable iff (rst)
    (consume1 && hdr_end) |=> v2)
    else $error("header end not captured for resolution");

  // An item leaves the input register only when the resolution stage has room.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (consume1 && hdr_end && v2) |-> ready3)
    else $error("resolution stage overrun");

endmodule
